[design/psn_pkg.sv]
// shared types for the point sort by norm block
`timescale 1ns / 1ps
`default_nettype none

package psn_pkg;

  // sequencer states of the load, insert and drain control
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_KEY,
    ST_CMP,
    ST_PUT,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

[design/psn_ram.sv]
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module psn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held while no read is enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/point_sort_by_norm.sv]
// top level of the point sort by norm block
//
// Collects a list of signed points, one per request, and after the request marked
// tlast sends the list back ascending by x*x+y*y, then min(|x|,|y|), then |x|+|y|,
// then x, then y. The list is kept sorted as it is loaded: each point is turned into
// a sort key (two squarers, then one add), then an insertion walks the key RAM from
// the top down, one read and one write per cycle, shifting up each stored point
// that sorts after the new one; a point that finds the store full is dropped and
// sets tuser on every result of that list. After the last point the list drains
// at one result per cycle while out_tready stays high, each result read from the
// RAM and then loaded into the output register. The store is only read where the
// current list wrote it, so no clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module point_sort_by_norm #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_tvalid,
  output logic                                         in_tready,
  input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]       in_tdata,  // x_coord, y_coord
  input  wire logic                                    in_tlast,  // last_point
  output logic                                         out_tvalid,
  input  wire logic                                    out_tready,
  output logic      [((2*COORD_BITS+7)/8)*8-1:0]       out_tdata, // out_x, out_y
  output logic                                         out_tlast, // out_last
  output logic                                         out_tuser  // overflow
);

  localparam int CB  = COORD_BITS;
  localparam int AW  = $clog2(MAX_POINTS);
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int KW  = 6 * CB + 1;
  localparam int TDW = ((2 * CB + 7) / 8) * 8;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);
  localparam logic [AW-1:0] ADR_ONE = AW'(1);

  psn_pkg::state_t state_r, state_nxt;

  // control registers
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          pend_r, pend_nxt;
  logic          pend_last_r, pend_last_nxt;
  logic          out_valid_r, out_valid_nxt;

  // payload registers
  logic [CB-1:0]   x_r, x_nxt;
  logic [CB-1:0]   y_r, y_nxt;
  logic            last_r, last_nxt;
  logic [2*CB-1:0] sqx_r, sqx_nxt;
  logic [2*CB-1:0] sqy_r, sqy_nxt;
  logic [CB-1:0]   m_r, m_nxt;
  logic [CB:0]     s_r, s_nxt;
  logic [KW-1:0]   key_r, key_nxt;
  logic [AW-1:0]   j_r, j_nxt;
  logic [CB-1:0]   ox_r, ox_nxt;
  logic [CB-1:0]   oy_r, oy_nxt;
  logic            olast_r, olast_nxt;
  logic            oovf_r, oovf_nxt;

  // ram ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [KW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [KW-1:0] ram_rdata;

  // magnitudes of the latched point
  logic [CB-1:0]   ax, ay;
  logic [2*CB-1:0] sqx, sqy;
  logic            accept, load, issue, fin;

  assign ax  = x_r[CB-1] ? (CB'(0) - x_r) : x_r;
  assign ay  = y_r[CB-1] ? (CB'(0) - y_r) : y_r;
  assign sqx = ax * ax;
  assign sqy = ay * ay;

  assign in_tready = (state_r == psn_pkg::ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  psn_ram #(
    .WIDTH (KW),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state, ram control and output register loading
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    k_nxt         = k_r;
    pend_nxt      = pend_r;
    pend_last_nxt = pend_last_r;
    out_valid_nxt = out_valid_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    last_nxt      = last_r;
    sqx_nxt       = sqx_r;
    sqy_nxt       = sqy_r;
    m_nxt         = m_r;
    s_nxt         = s_r;
    key_nxt       = key_r;
    j_nxt         = j_r;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    olast_nxt     = olast_r;
    oovf_nxt      = oovf_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = key_r;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    load          = 1'b0;
    issue         = 1'b0;
    fin           = 1'b0;

    // output register empties on a taken result
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      psn_pkg::ST_IDLE: begin
        if (accept) begin
          x_nxt    = in_tdata[CB-1:0];
          y_nxt    = in_tdata[2*CB-1:CB];
          last_nxt = in_tlast;
          if (count_r < MAX_CNT) begin
            state_nxt = psn_pkg::ST_SQ;
          end else begin
            ovf_nxt = 1'b1;
            if (in_tlast) begin
              state_nxt = psn_pkg::ST_OUT;
            end
          end
        end
      end
      psn_pkg::ST_SQ: begin
        sqx_nxt   = sqx;
        sqy_nxt   = sqy;
        m_nxt     = (ax < ay) ? ax : ay;
        s_nxt     = {1'b0, ax} + {1'b0, ay};
        state_nxt = psn_pkg::ST_KEY;
      end
      psn_pkg::ST_KEY: begin
        // key: norm, min, sum, biased x, biased y
        key_nxt = {sqx_r + sqy_r, m_r, s_r,
                   ~x_r[CB-1], x_r[CB-2:0], ~y_r[CB-1], y_r[CB-2:0]};
        if (count_r == '0) begin
          state_nxt = psn_pkg::ST_PUT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = count_r[AW-1:0] - ADR_ONE;
          j_nxt     = count_r[AW-1:0] - ADR_ONE;
          state_nxt = psn_pkg::ST_CMP;
        end
      end
      psn_pkg::ST_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = j_r + ADR_ONE;
        if (ram_rdata > key_r) begin
          // entry sorts after the new point, shift it up
          ram_wdata = ram_rdata;
          if (j_r == '0) begin
            state_nxt = psn_pkg::ST_PUT;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = j_r - ADR_ONE;
            j_nxt     = j_r - ADR_ONE;
          end
        end else begin
          ram_wdata = key_r;
          fin       = 1'b1;
        end
      end
      psn_pkg::ST_PUT: begin
        // new point goes to the bottom of the store
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = key_r;
        fin       = 1'b1;
      end
      psn_pkg::ST_OUT: begin
        load  = pend_r && (!out_valid_r || out_tready);
        issue = (k_r < count_r) && (!pend_r || load);
        if (issue) begin
          ram_re        = 1'b1;
          ram_raddr     = k_r[AW-1:0];
          k_nxt         = k_r + CNT_ONE;
          pend_last_nxt = (k_r == count_r - CNT_ONE);
        end
        pend_nxt = issue || (pend_r && !load);
        if (load) begin
          out_valid_nxt = 1'b1;
          ox_nxt        = {~ram_rdata[2*CB-1], ram_rdata[2*CB-2:CB]};
          oy_nxt        = {~ram_rdata[CB-1], ram_rdata[CB-2:0]};
          olast_nxt     = pend_last_r;
          oovf_nxt      = ovf_r;
          if (pend_last_r) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            k_nxt     = '0;
            state_nxt = psn_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = psn_pkg::ST_IDLE;
      end
    endcase

    // insertion done
    if (fin) begin
      count_nxt = count_r + CNT_ONE;
      state_nxt = last_r ? psn_pkg::ST_OUT : psn_pkg::ST_IDLE;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psn_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      k_r         <= '0;
      pend_r      <= 1'b0;
      pend_last_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      k_r         <= k_nxt;
      pend_r      <= pend_nxt;
      pend_last_r <= pend_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    last_r  <= last_nxt;
    sqx_r   <= sqx_nxt;
    sqy_r   <= sqy_nxt;
    m_r     <= m_nxt;
    s_r     <= s_nxt;
    key_r   <= key_nxt;
    j_r     <= j_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    olast_r <= olast_nxt;
    oovf_r  <= oovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDW'({oy_r, ox_r});
  assign out_tlast  = olast_r;
  assign out_tuser  = oovf_r;

endmodule

`default_nettype wire

[design/psn_checker.sv]
// port level checks of the point sort by norm block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module psn_checker #(
  parameter int COORD_BITS = 16
) (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic                              in_tlast,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [((2*COORD_BITS+7)/8)*8-1:0] out_tdata,
  input wire logic                              out_tlast,
  input wire logic                              out_tuser
);

  // reset leaves the block ready for a list with nothing to send
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (in_tready && !out_tvalid))
    else $error("block not idle after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser)))
    else $error("stalled result changed");

  // the last point of a list starts work, no request taken next cycle
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !in_tready)
    else $error("request taken right after last point");

endmodule

bind point_sort_by_norm psn_checker #(
  .COORD_BITS (COORD_BITS)
) u_psn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire

[tb/point_sort_by_norm_tb.sv]
// testbench for the point sort by norm block: streams point lists, checks each sorted run
`timescale 1ns / 1ps

module point_sort_by_norm_tb;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 16;
  localparam int DATA_W     = ((2*COORD_BITS+7)/8)*8;
  localparam int TX_MAX_GAP = 10;
  localparam int RX_MAX_GAP = 10;
  localparam int HOLD_LEN   = 300;
  localparam int RANDOM_ITEMS = 120;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct {
    coord_t x;
    coord_t y;
    bit     last;
    bit     dropped;
  } sorted_point_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata;   // x_coord, y_coord
  logic              in_tlast;   // last_point
  logic              out_tvalid;
  logic              out_tready;
  logic [DATA_W-1:0] out_tdata;  // out_x, out_y
  logic              out_tlast;  // out_last
  logic              out_tuser;  // overflow

  // points of the list being loaded and the sorted runs still to come out
  point_t        open_list[$];
  bit            open_list_dropped;
  sorted_point_t sorted_expect_q[$];
  point_t        prev_pt;

  int errors;
  int tx_max_gap;
  int rx_max_gap;
  bit rx_hold_req;
  int rx_hold_len;

  point_sort_by_norm #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // 1 when point a sorts strictly after point b
  function automatic bit sorts_after(point_t a, point_t b);
    longint ax, ay, bx, by, ra, rb, ma, mb, sa, sb;
    ax = (a.x < 0) ? -longint'(a.x) : longint'(a.x);
    ay = (a.y < 0) ? -longint'(a.y) : longint'(a.y);
    bx = (b.x < 0) ? -longint'(b.x) : longint'(b.x);
    by = (b.y < 0) ? -longint'(b.y) : longint'(b.y);
    ra = ax*ax + ay*ay;
    rb = bx*bx + by*by;
    ma = (ax < ay) ? ax : ay;
    mb = (bx < by) ? bx : by;
    sa = ax + ay;
    sb = bx + by;
    if (ra != rb) return ra > rb;
    if (ma != mb) return ma > mb;
    if (sa != sb) return sa > sb;
    if (a.x != b.x) return a.x > b.x;
    return a.y > b.y;
  endfunction

  // store one accepted point; on the last one sort the list and queue the run
  task automatic load_point(point_t p, bit last);
    int     i, j, n;
    point_t key;
    if (open_list.size() < MAX_POINTS) begin
      open_list.push_back(p);
    end else begin
      open_list_dropped = 1'b1;
    end
    if (last) begin
      n = open_list.size();
      for (i = 1; i < n; i++) begin
        key = open_list[i];
        j = i;
        while (j > 0 && sorts_after(open_list[j-1], key)) begin
          open_list[j] = open_list[j-1];
          j--;
        end
        open_list[j] = key;
      end
      for (i = 0; i < n; i++) begin
        sorted_expect_q.push_back('{open_list[i].x, open_list[i].y, i == n-1,
                                    open_list_dropped});
      end
      open_list.delete();
      open_list_dropped = 1'b0;
    end
  endtask

  // offer one request after a random gap and wait until it is taken
  task automatic send_point(point_t p, bit last);
    int gap;
    gap = (tx_max_gap == 0) ? 0 : $urandom_range(0, tx_max_gap);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {p.y, p.x};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    load_point(p, last);
  endtask

  // stop offering and wait until every queued result has come out
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sorted_expect_q.size() != 0) @(posedge clk);
  endtask

  // random point: full range, small values, same norm as before, edge values, repeats
  function automatic point_t next_point();
    point_t p;
    case ($urandom_range(0, 4))
      0: begin
        p.x = coord_t'($urandom_range(0, 65535));
        p.y = coord_t'($urandom_range(0, 65535));
      end
      1: begin
        p.x = coord_t'($signed($urandom_range(0, 16)) - 8);
        p.y = coord_t'($signed($urandom_range(0, 16)) - 8);
      end
      2: begin
        case ($urandom_range(0, 3))
          0: p = '{prev_pt.y, prev_pt.x};
          1: p = '{-prev_pt.x, prev_pt.y};
          2: p = '{prev_pt.x, -prev_pt.y};
          default: p = '{-prev_pt.y, -prev_pt.x};
        endcase
      end
      3: begin
        case ($urandom_range(0, 5))
          0: p.x = -32768;
          1: p.x = -32767;
          2: p.x = -1;
          3: p.x = 0;
          4: p.x = 1;
          default: p.x = 32767;
        endcase
        case ($urandom_range(0, 5))
          0: p.y = -32768;
          1: p.y = -32767;
          2: p.y = -1;
          3: p.y = 0;
          4: p.y = 1;
          default: p.y = 32767;
        endcase
      end
      default: p = prev_pt;
    endcase
    prev_pt = p;
    return p;
  endfunction

  task automatic send_random_list(int len);
    int k;
    for (k = 0; k < len; k++) begin
      send_point(next_point(), k == len-1);
    end
  endtask

  // receiver: random stall before each result, or one long hold when asked
  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (rx_hold_req) begin
        stall = rx_hold_len;
        rx_hold_req = 1'b0;
      end else begin
        stall = (rx_max_gap == 0) ? 0 : $urandom_range(0, rx_max_gap);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready) && !rx_hold_req);
      @(negedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    sorted_point_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (sorted_expect_q.size() == 0) begin
        $error("unexpected result x=%0d y=%0d last=%0b overflow=%0b",
               $signed(out_tdata[15:0]), $signed(out_tdata[31:16]), out_tlast, out_tuser);
        errors++;
      end else begin
        want = sorted_expect_q.pop_front();
        if (out_tdata[15:0] !== want.x) begin
          $error("out_x expected %0d got %0d", want.x, $signed(out_tdata[15:0]));
          errors++;
        end
        if (out_tdata[31:16] !== want.y) begin
          $error("out_y expected %0d got %0d", want.y, $signed(out_tdata[31:16]));
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("out_last expected %0b got %0b", want.last, out_tlast);
          errors++;
        end
        if (out_tuser !== want.dropped) begin
          $error("overflow expected %0b got %0b", want.dropped, out_tuser);
          errors++;
        end
        if ((out_tdata >> 32) !== '0) begin
          $error("out_tdata pad expected 0 got %0h", out_tdata);
          errors++;
        end
      end
    end
  end

  // one-point lists at the coordinate extremes
  task automatic test_single_point();
    send_point('{-32768, 32767}, 1'b1);
    send_point('{0, 0}, 1'b1);
  endtask

  // extremes of both fields in one list
  task automatic test_extremes();
    send_point('{32767, 32767}, 1'b0);
    send_point('{-32768, -32768}, 1'b0);
    send_point('{0, 0}, 1'b0);
    send_point('{-32768, 0}, 1'b0);
    send_point('{0, -32768}, 1'b0);
    send_point('{32767, -32768}, 1'b0);
    send_point('{1, -1}, 1'b1);
  endtask

  // equal norms so the min, x and y tie breaks decide, plus an identical pair
  task automatic test_norm_ties();
    send_point('{3, 4}, 1'b0);
    send_point('{0, -5}, 1'b0);
    send_point('{4, 3}, 1'b0);
    send_point('{-5, 0}, 1'b0);
    send_point('{5, 0}, 1'b0);
    send_point('{-3, -4}, 1'b0);
    send_point('{0, 5}, 1'b0);
    send_point('{3, 4}, 1'b0);
    send_point('{4, -3}, 1'b0);
    send_point('{-4, 3}, 1'b1);
  endtask

  // a list that just fits, then one whose tail and last point are dropped
  task automatic test_store_limit();
    send_random_list(MAX_POINTS);
    send_random_list(MAX_POINTS + 2);
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_output_hold();
    wait_drained();
    @(negedge clk);
    rx_hold_len = HOLD_LEN;
    rx_hold_req = 1'b1;
    send_random_list(6);
    send_random_list(5);
  endtask

  // back-to-back lists with no idling, the sender waiting for each run to finish
  task automatic test_drained_pauses();
    int k;
    tx_max_gap = 0;
    rx_max_gap = 0;
    for (k = 0; k < 4; k++) begin
      send_random_list($urandom_range(1, 12));
      wait_drained();
    end
    tx_max_gap = TX_MAX_GAP;
    rx_max_gap = RX_MAX_GAP;
  endtask

  // random lists, mostly short, with changing idling on each side
  task automatic test_random_lists();
    int sent, len, r;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        len = $urandom_range(1, 8);
      end else if (r < 95) begin
        len = $urandom_range(9, 40);
      end else if (r < 98) begin
        len = $urandom_range(41, MAX_POINTS);
      end else begin
        len = $urandom_range(MAX_POINTS + 1, MAX_POINTS + 3);
      end
      case ($urandom_range(0, 9))
        0: begin
          tx_max_gap = 0;
          rx_max_gap = 0;
        end
        1: begin
          tx_max_gap = 0;
          rx_max_gap = RX_MAX_GAP;
        end
        2: begin
          tx_max_gap = TX_MAX_GAP;
          rx_max_gap = 0;
        end
        default: begin
          tx_max_gap = TX_MAX_GAP;
          rx_max_gap = RX_MAX_GAP;
        end
      endcase
      send_random_list(len);
      sent += len;
      if ($urandom_range(0, 7) == 0) begin
        wait_drained();
      end
    end
  endtask

  // main sequence
  initial begin
    errors            = 0;
    tx_max_gap        = TX_MAX_GAP;
    rx_max_gap        = RX_MAX_GAP;
    rx_hold_req       = 1'b0;
    rx_hold_len       = 0;
    open_list_dropped = 1'b0;
    prev_pt           = '{7, -3};
    rst_n             = 1'b0;
    in_tvalid         = 1'b0;
    in_tdata          = '0;
    in_tlast          = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_single_point();
    test_extremes();
    test_norm_ties();
    test_store_limit();
    test_output_hold();
    test_drained_pauses();
    test_random_lists();

    wait_drained();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
